@@ rtl/ppm_pkg.sv @@
// Shared types, constants and helper functions for the pedal plausibility monitor.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package ppm_pkg;

  localparam int POS_W  = 10;
  localparam int TIME_W = 16;
  localparam int IDX_W  = 3;

  localparam logic [TIME_W-1:0] TICK_MS     = TIME_W'(10);
  localparam logic [TIME_W-1:0] ELAPSED_MAX = {TIME_W{1'b1}};

  typedef enum logic [IDX_W-1:0] {
    REG_DISAGREE_THRESHOLD   = 3'd0,
    REG_DISAGREE_TIMEOUT     = 3'd1,
    REG_DISAGREE_RECOVERY    = 3'd2,
    REG_DOUBLE_TIMEOUT       = 3'd3,
    REG_DOUBLE_APPLY         = 3'd4,
    REG_DOUBLE_RECOVER       = 3'd5
  } reg_index_t;

  typedef enum logic [1:0] {
    DP_AGREE            = 2'd0,
    DP_DISAGREE         = 2'd1,
    DP_DISAGREE_FAULTED = 2'd2,
    DP_AGREE_FAULTED    = 2'd3
  } disagree_phase_t;

  typedef enum logic [1:0] {
    DB_NOT_ACTIVE = 2'd0,
    DB_DOUBLE     = 2'd1,
    DB_FAULTED    = 2'd2
  } double_phase_t;

  typedef struct packed {
    logic [POS_W-1:0]  disagree_threshold;
    logic [TIME_W-1:0] disagree_timeout_ms;
    logic [TIME_W-1:0] disagree_recovery_ms;
    logic [TIME_W-1:0] double_timeout_ms;
    logic [POS_W-1:0]  double_apply_threshold;
    logic [POS_W-1:0]  double_recover_threshold;
  } cfg_regs_t;

  // Elapsed-time counters add one tick and stop at the top of their range.
  function automatic logic [TIME_W-1:0] tick_add(input logic [TIME_W-1:0] v);
    logic [TIME_W:0] s;
    s = {1'b0, v} + {1'b0, TICK_MS};
    return s[TIME_W] ? ELAPSED_MAX : s[TIME_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/pedal_plausibility_monitor.sv @@
// Top level of the pedal plausibility monitor: input register, checks, result register.
// Depends on ppm_pkg, ppm_config, ppm_disagree_fsm and ppm_double_fsm.
`default_nettype none

// Each request on the s_ side is one 10 ms tick of pedal data and yields exactly one
// result on the m_ side. A request is captured in an input register; when the result
// register can take a value, both state machines advance and the result register is
// loaded, so one tick can be taken every cycle as long as results are drained.
// The result register decouples the sides: a new tick is accepted into an empty input
// register while a finished result is still waiting. Configuration writes are applied
// immediately and should only be issued while no tick is in flight.

module pedal_plausibility_monitor
  import ppm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  // [9:0] pos_a, [19:10] pos_b, [29:20] pos_average, [30] brake_applied, [31] accel_rational
  input  wire logic [31:0]       s_tdata,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  // [0] disagree_fault, [1] double_fault, [11:2] position_error, [15:12] zero
  output logic [15:0]            m_tdata,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [IDX_W-1:0]  cfg_index,
  input  wire logic [TIME_W-1:0] cfg_data
);

  cfg_regs_t regs;

  logic             in_valid;
  logic [31:0]      in_data;
  logic             advance, step;

  logic [POS_W-1:0] pos_a, pos_b, pos_average;
  logic             brake_applied, accel_rational;
  logic [POS_W-1:0] position_error;
  logic             ok, pressed, released;
  logic             disagree_fault_next, double_fault_next;

  assign cfg_ready = 1'b1;

  ppm_config u_config (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .regs     (regs)
  );

  // The result register can take a new value when it is empty or being drained.
  assign advance  = !m_tvalid || m_tready;
  assign step     = in_valid && advance;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_data <= s_tdata;
    end
  end

  assign pos_a          = in_data[9:0];
  assign pos_b          = in_data[19:10];
  assign pos_average    = in_data[29:20];
  assign brake_applied  = in_data[30];
  assign accel_rational = in_data[31];

  assign position_error = (pos_a >= pos_b) ? (pos_a - pos_b) : (pos_b - pos_a);
  assign ok       = (position_error < regs.disagree_threshold) && accel_rational;
  assign pressed  = brake_applied && (pos_average > regs.double_apply_threshold);
  assign released = (pos_average <= regs.double_recover_threshold);

  ppm_disagree_fsm u_disagree (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .ok          (ok),
    .timeout_ms  (regs.disagree_timeout_ms),
    .recovery_ms (regs.disagree_recovery_ms),
    .fault_next  (disagree_fault_next)
  );

  ppm_double_fsm u_double (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .pressed    (pressed),
    .released   (released),
    .timeout_ms (regs.double_timeout_ms),
    .fault_next (double_fault_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      m_tdata <= {4'b0000, position_error, double_fault_next, disagree_fault_next};
    end
  end

endmodule

`default_nettype wire

@@ rtl/ppm_config.sv @@
// Configuration register file of the pedal plausibility monitor.
// Depends on ppm_pkg for the register indexes and the register struct.
`default_nettype none

module ppm_config
  import ppm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              wr_en,
  input  wire logic [IDX_W-1:0]  wr_index,
  input  wire logic [TIME_W-1:0] wr_data,
  output cfg_regs_t              regs
);

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.disagree_threshold       <= POS_W'(100);
      regs.disagree_timeout_ms      <= TIME_W'(100);
      regs.disagree_recovery_ms     <= TIME_W'(1000);
      regs.double_timeout_ms        <= TIME_W'(500);
      regs.double_apply_threshold   <= POS_W'(250);
      regs.double_recover_threshold <= POS_W'(50);
    end else if (wr_en) begin
      case (wr_index)
        REG_DISAGREE_THRESHOLD: regs.disagree_threshold       <= wr_data[POS_W-1:0];
        REG_DISAGREE_TIMEOUT:   regs.disagree_timeout_ms      <= wr_data;
        REG_DISAGREE_RECOVERY:  regs.disagree_recovery_ms     <= wr_data;
        REG_DOUBLE_TIMEOUT:     regs.double_timeout_ms        <= wr_data;
        REG_DOUBLE_APPLY:       regs.double_apply_threshold   <= wr_data[POS_W-1:0];
        REG_DOUBLE_RECOVER:     regs.double_recover_threshold <= wr_data[POS_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/ppm_disagree_fsm.sv @@
// Sensor disagreement state machine with its elapsed-time counter.
// Depends on ppm_pkg for the phase type and the tick counter helper.
`default_nettype none

module ppm_disagree_fsm
  import ppm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              step,
  input  wire logic              ok,
  input  wire logic [TIME_W-1:0] timeout_ms,
  input  wire logic [TIME_W-1:0] recovery_ms,
  output logic                   fault_next
);

  disagree_phase_t   phase, phase_next;
  logic [TIME_W-1:0] elapsed, elapsed_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= DP_AGREE;
      elapsed <= '0;
    end else if (step) begin
      phase   <= phase_next;
      elapsed <= elapsed_next;
    end
  end

  always_comb begin
    phase_next = phase;
    case (phase)
      DP_AGREE: begin
        if (!ok) phase_next = DP_DISAGREE;
      end
      DP_DISAGREE: begin
        if (ok) phase_next = DP_AGREE;
        else if (elapsed >= timeout_ms) phase_next = DP_DISAGREE_FAULTED;
      end
      DP_DISAGREE_FAULTED: begin
        if (ok) phase_next = DP_AGREE_FAULTED;
      end
      DP_AGREE_FAULTED: begin
        if (!ok) phase_next = DP_DISAGREE_FAULTED;
        else if (elapsed >= recovery_ms) phase_next = DP_AGREE;
      end
      default: phase_next = DP_AGREE;
    endcase
    // A transition restarts the count before this tick is added.
    elapsed_next = tick_add((phase_next != phase) ? '0 : elapsed);
    fault_next   = (phase_next == DP_DISAGREE_FAULTED) || (phase_next == DP_AGREE_FAULTED);
  end

endmodule

`default_nettype wire

@@ rtl/ppm_double_fsm.sv @@
// Double pedal (brake and accelerator together) state machine with its counter.
// Depends on ppm_pkg for the phase type and the tick counter helper.
`default_nettype none

module ppm_double_fsm
  import ppm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              step,
  input  wire logic              pressed,
  input  wire logic              released,
  input  wire logic [TIME_W-1:0] timeout_ms,
  output logic                   fault_next
);

  double_phase_t     phase, phase_next;
  logic [TIME_W-1:0] elapsed, elapsed_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= DB_NOT_ACTIVE;
      elapsed <= '0;
    end else if (step) begin
      phase   <= phase_next;
      elapsed <= elapsed_next;
    end
  end

  always_comb begin
    case (phase)
      DB_DOUBLE: begin
        if (!pressed) phase_next = DB_NOT_ACTIVE;
        else if (elapsed >= timeout_ms) phase_next = DB_FAULTED;
        else phase_next = DB_DOUBLE;
      end
      DB_FAULTED: begin
        phase_next = released ? DB_NOT_ACTIVE : DB_FAULTED;
      end
      default: begin
        phase_next = pressed ? DB_DOUBLE : DB_NOT_ACTIVE;
      end
    endcase
    elapsed_next = tick_add((phase_next != phase) ? '0 : elapsed);
    fault_next   = (phase_next == DB_FAULTED);
  end

endmodule

`default_nettype wire
